FILE: hdl/periodic_timer_table_macros.svh
// Assertion macros for the periodic timer table.
// Included by the RTL files that carry checks; expects signals clock and reset.
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// Property checked on every rising clock edge outside of reset
`define PTT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every rising clock edge, reset included
`define PTT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: hdl/ptt_pkg.sv
// Shared constants, codes and types of the periodic timer table.
// No dependencies; used by the cell, the top level and the testbench.
`timescale 1ns / 1ps

package ptt_pkg;

   // Table size and index widths
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PTR_W   = $clog2(ENTRIES + 1);

   // Request opcodes
   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_KILL  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Response kinds
   localparam logic [1:0] KIND_OK    = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;

   // Commands broadcast to the cell chain
   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_UPDATE = 3'd1;
   localparam logic [2:0] CELL_INSERT = 3'd2;
   localparam logic [2:0] CELL_KILL   = 3'd3;
   localparam logic [2:0] CELL_CLEAR  = 3'd4;
   localparam logic [2:0] CELL_TICK   = 3'd5;
   localparam logic [2:0] CELL_SHIFT  = 3'd6;
   localparam logic [2:0] CELL_ACK    = 3'd7;

   // Contents of one table cell
   typedef struct packed {
      logic        valid;
      logic        killed;
      logic        fired;
      logic [31:0] id;
      logic [31:0] period;
      logic [31:0] stamp;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '0;

   // Broadcast control to every cell
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] event_id;
      logic [31:0] period;
      logic [31:0] now;
   } ctl_type;

   // Per-cell status back to the controller and the next cell
   typedef struct packed {
      logic hit;   // valid and id equals the broadcast id
      logic ins;   // free, or holds an id above the broadcast id
   } stat_type;

endpackage

FILE: hdl/ptt_if.sv
// Valid/ready channel interfaces of the periodic timer table.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

// Request channel: one operation per transfer
interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] event_id;
   logic [31:0] period;
   logic [31:0] now;

   modport source (output valid, opcode, event_id, period, now, input ready);
   modport sink   (input valid, opcode, event_id, period, now, output ready);
endinterface

// Response channel: one result per transfer
interface ptt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] fired_id;
   logic        last;

   modport source (output valid, kind, fired_id, last, input ready);
   modport sink   (input valid, kind, fired_id, last, output ready);
endinterface

FILE: hdl/periodic_timer_table.sv
// Top level of the periodic timer table: controller, scan and response register.
// Depends on ptt_pkg, ptt_if.sv, ptt_cell and periodic_timer_table_macros.svh.
`timescale 1ns / 1ps
`include "periodic_timer_table_macros.svh"

// The table holds up to ENTRIES timers in a chain of cells kept packed and in
// ascending event id order, so a tick reports fired timers by walking the chain
// from the front. One request is handled at a time: it is taken in the cycle
// after the previous one finished, while its result may still wait in the
// response register. Set, kill and clear give their single result from the
// response register once it is free. A tick evaluates every timer in parallel,
// then walks the chain one step a cycle while no fired report waits, each step
// either passing one live timer (reporting it if it fired) or closing one gap
// left by a freed timer, and then issues the done result. The walk is the rate
// limiter; each fired report waits for the response register to free up.
module periodic_timer_table (
   input  logic            clock,
   input  logic            reset,
   ptt_req_if.sink         req_bus,
   ptt_rsp_if.source       rsp_bus
);

   localparam int N = ptt_pkg::ENTRIES;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [ptt_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic [1:0]               cmd_op_ff, cmd_op_in;
   logic [31:0]              cmd_id_ff, cmd_id_in;
   logic [31:0]              cmd_period_ff, cmd_period_in;
   logic [31:0]              cmd_now_ff, cmd_now_in;

   logic                     out_valid_ff, out_valid_in;
   logic [1:0]               out_kind_ff, out_kind_in;
   logic [31:0]              out_id_ff, out_id_in;
   logic                     out_last_ff, out_last_in;
   logic                     load_out;
   logic                     out_free;
   logic                     req_fire;

   ptt_pkg::ctl_type         ctl;
   ptt_pkg::entry_type       cell_entry [N];
   ptt_pkg::stat_type        cell_stat [N];
   ptt_pkg::entry_type       cur;
   logic [N-1:0]             valid_vec;
   logic [N-1:0]             fired_vec;
   logic [N-1:0]             hit_vec;
   logic [N-1:0]             ge_vec;
   logic [N-1:0]             valid_inc;
   logic                     any_hit;
   logic                     full;
   logic                     rest_valid;

   // Cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      ptt_pkg::entry_type left_entry;
      ptt_pkg::entry_type right_entry;
      logic               left_ins;

      if (i == 0) begin : g_first
         assign left_entry = ptt_pkg::ENTRY_EMPTY;
         assign left_ins   = 1'b0;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
         assign left_ins   = cell_stat[i-1].ins;
      end

      if (i == N - 1) begin : g_last
         assign right_entry = ptt_pkg::ENTRY_EMPTY;
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      assign ge_vec[i]    = ptr_ff <= ptt_pkg::PTR_W'(i);
      assign valid_vec[i] = cell_entry[i].valid;
      assign fired_vec[i] = cell_entry[i].fired;
      assign hit_vec[i]   = cell_stat[i].hit;

      ptt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_ins    (left_ins),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .sel         (ptr_ff == ptt_pkg::PTR_W'(i)),
         .at_or_after (ge_vec[i]),
         .entry       (cell_entry[i]),
         .stat        (cell_stat[i])
      );
   end

   // Chain summaries
   assign any_hit    = |hit_vec;
   assign full       = valid_vec[N-1];
   assign rest_valid = |(valid_vec & ge_vec);
   assign valid_inc  = valid_vec + (N)'(1);
   assign cur        = cell_entry[ptr_ff[ptt_pkg::IDX_W-1:0]];

   // Handshakes
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign req_bus.ready   = state_ff == S_IDLE;
   assign out_free        = !out_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.kind     = out_kind_ff;
   assign rsp_bus.fired_id = out_id_ff;
   assign rsp_bus.last     = out_last_ff;

   // Request capture
   always_comb begin
      cmd_op_in     = cmd_op_ff;
      cmd_id_in     = cmd_id_ff;
      cmd_period_in = cmd_period_ff;
      cmd_now_in    = cmd_now_ff;
      if (req_fire) begin
         cmd_op_in     = req_bus.opcode;
         cmd_id_in     = req_bus.event_id;
         cmd_period_in = req_bus.period;
         cmd_now_in    = req_bus.now;
      end
   end

   // Controller
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      ctl.cmd      = ptt_pkg::CELL_HOLD;
      ctl.event_id = cmd_id_ff;
      ctl.period   = cmd_period_ff;
      ctl.now      = cmd_now_ff;
      load_out     = 1'b0;
      out_kind_in  = ptt_pkg::KIND_OK;
      out_id_in    = '0;
      out_last_in  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_op_ff == ptt_pkg::OP_TICK) begin
               ctl.cmd  = ptt_pkg::CELL_TICK;
               ptr_in   = '0;
               state_in = S_SCAN;
            end else if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
               case (cmd_op_ff)
                  ptt_pkg::OP_SET: begin
                     if (any_hit) begin
                        ctl.cmd = ptt_pkg::CELL_UPDATE;
                     end else if (full) begin
                        out_kind_in = ptt_pkg::KIND_FULL;
                     end else begin
                        ctl.cmd = ptt_pkg::CELL_INSERT;
                     end
                  end
                  ptt_pkg::OP_KILL:  ctl.cmd = ptt_pkg::CELL_KILL;
                  ptt_pkg::OP_CLEAR: ctl.cmd = ptt_pkg::CELL_CLEAR;
                  default:           ctl.cmd = ptt_pkg::CELL_HOLD;
               endcase
            end
         end
         S_SCAN: begin
            // one live entry passed or one gap closed per cycle unless a fired entry waits for the response register
            if (ptr_ff == ptt_pkg::PTR_W'(N)) begin
               state_in = S_DONE;
            end else if (cur.valid) begin
               if (cur.fired) begin
                  if (out_free) begin
                     load_out    = 1'b1;
                     out_kind_in = ptt_pkg::KIND_FIRED;
                     out_id_in   = cur.id;
                     out_last_in = 1'b0;
                     ctl.cmd     = ptt_pkg::CELL_ACK;
                     ptr_in      = ptr_ff + 1'b1;
                  end
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else if (rest_valid) begin
               ctl.cmd = ptt_pkg::CELL_SHIFT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Response register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_op_ff     <= cmd_op_in;
      cmd_id_ff     <= cmd_id_in;
      cmd_period_ff <= cmd_period_in;
      cmd_now_ff    <= cmd_now_in;
      if (load_out) begin
         out_kind_ff <= out_kind_in;
         out_id_ff   <= out_id_in;
         out_last_ff <= out_last_in;
      end
   end

   // Checks
   `PTT_ASSERT(a_packed_idle, (state_ff == S_IDLE |-> (valid_vec & valid_inc) == '0), "chain not packed while idle")
   `PTT_ASSERT(a_no_fired_idle, (state_ff == S_IDLE |-> fired_vec == '0), "fired flag left after tick")
   `PTT_ASSERT(a_unique_hit, ($onehot0(hit_vec)), "event id held by more than one cell")
   `PTT_ASSERT(a_fired_not_last, (out_valid_ff && out_kind_ff == ptt_pkg::KIND_FIRED |-> !out_last_ff), "fired result marked last")
   `PTT_ASSERT_ALWAYS(a_busy_after_req, (!reset && req_fire |=> state_ff == S_EXEC), "request transfer not followed by execution")

endmodule

FILE: hdl/ptt_cell.sv
// One cell of the timer chain: holds a single timer entry.
// Depends on ptt_pkg; trades entries with its left and right neighbors.
`timescale 1ns / 1ps

module ptt_cell (
   input  logic                clock,
   input  logic                reset,
   input  ptt_pkg::ctl_type    ctl,
   input  logic                left_ins,
   input  ptt_pkg::entry_type  left_entry,
   input  ptt_pkg::entry_type  right_entry,
   input  logic                sel,
   input  logic                at_or_after,
   output ptt_pkg::entry_type  entry,
   output ptt_pkg::stat_type   stat
);

   logic        valid_ff, valid_in;
   logic        killed_ff, killed_in;
   logic        fired_ff, fired_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] period_ff, period_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [31:0] elapsed;
   logic        due;

   assign entry = '{valid: valid_ff, killed: killed_ff, fired: fired_ff,
                    id: id_ff, period: period_ff, stamp: stamp_ff};

   // Match and ordering against the broadcast id
   assign stat.hit = valid_ff && (id_ff == ctl.event_id);
   assign stat.ins = !valid_ff || (id_ff > ctl.event_id);

   // Wrapping age of the entry
   assign elapsed = ctl.now - stamp_ff;
   assign due     = elapsed > period_ff;

   // Next entry contents
   always_comb begin
      valid_in  = valid_ff;
      killed_in = killed_ff;
      fired_in  = fired_ff;
      id_in     = id_ff;
      period_in = period_ff;
      stamp_in  = stamp_ff;
      case (ctl.cmd)
         ptt_pkg::CELL_UPDATE: begin
            if (stat.hit) begin
               period_in = ctl.period;
               stamp_in  = ctl.now;
               killed_in = 1'b0;
            end
         end
         ptt_pkg::CELL_INSERT: begin
            // cells from the insert point on move one place right
            if (stat.ins) begin
               if (left_ins) begin
                  valid_in  = left_entry.valid;
                  killed_in = left_entry.killed;
                  fired_in  = left_entry.fired;
                  id_in     = left_entry.id;
                  period_in = left_entry.period;
                  stamp_in  = left_entry.stamp;
               end else begin
                  valid_in  = 1'b1;
                  killed_in = 1'b0;
                  fired_in  = 1'b0;
                  id_in     = ctl.event_id;
                  period_in = ctl.period;
                  stamp_in  = ctl.now;
               end
            end
         end
         ptt_pkg::CELL_KILL: begin
            if (stat.hit) begin
               killed_in = 1'b1;
            end
         end
         ptt_pkg::CELL_CLEAR: begin
            valid_in  = 1'b0;
            killed_in = 1'b0;
            fired_in  = 1'b0;
         end
         ptt_pkg::CELL_TICK: begin
            // free killed timers, restamp and flag the expired ones
            if (valid_ff) begin
               if (killed_ff) begin
                  valid_in  = 1'b0;
                  killed_in = 1'b0;
               end else if (due) begin
                  stamp_in = ctl.now;
                  fired_in = 1'b1;
               end
            end
         end
         ptt_pkg::CELL_SHIFT: begin
            // close a gap: cells at and after the scan point pull from the right
            if (at_or_after) begin
               valid_in  = right_entry.valid;
               killed_in = right_entry.killed;
               fired_in  = right_entry.fired;
               id_in     = right_entry.id;
               period_in = right_entry.period;
               stamp_in  = right_entry.stamp;
            end
         end
         ptt_pkg::CELL_ACK: begin
            if (sel) begin
               fired_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         killed_ff <= 1'b0;
         fired_ff  <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         killed_ff <= killed_in;
         fired_ff  <= fired_in;
      end
   end

   // Timer payload
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      period_ff <= period_in;
      stamp_ff  <= stamp_in;
   end

endmodule

FILE: tb/sv/periodic_timer_table_test.sv
// Self-checking testbench for the periodic timer table: directed rows, then random traffic.
// Depends on ptt_pkg, the channel interfaces in ptt_if.sv and periodic_timer_table.
`timescale 1ns / 1ps

module periodic_timer_table_test;

   localparam int RANDOM_ITEMS = 126;
   localparam int PHASE_ITEMS  = 42;
   localparam int ID_POOL      = 18;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = ptt_pkg::ENTRIES + 8;
   localparam int DIRECTED     = 25;

   // One request; typed rows carry their single expected kind
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] event_id;
      logic [31:0] period;
      logic [31:0] now;
      logic        typed;
      logic [1:0]  typed_kind;
   } timer_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] fired_id;
      logic        last;
   } timer_rsp_type;

   logic clock;
   logic reset;

   ptt_req_if req_bus ();
   ptt_rsp_if rsp_bus ();

   periodic_timer_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Clock, 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Shadow copy of the timer table
   logic              tbl_valid  [ptt_pkg::ENTRIES];
   logic              tbl_killed [ptt_pkg::ENTRIES];
   logic [31:0]       tbl_id     [ptt_pkg::ENTRIES];
   logic [31:0]       tbl_period [ptt_pkg::ENTRIES];
   logic [31:0]       tbl_stamp  [ptt_pkg::ENTRIES];

   timer_rsp_type step_results [$];
   timer_rsp_type pending_results [$];

   int error_count = 0;
   int send_idle_pct = 8;
   int recv_stall_pct = 57;
   int quiet_cycles = 0;
   int op_count [4] = '{0, 0, 0, 0};
   int fired_seen = 0;
   int full_seen = 0;
   int rsp_seen = 0;

   timer_req_type directed_rows [DIRECTED];

   // Apply one request to the shadow table; results go to step_results
   function automatic void advance_timer_table(timer_req_type r);
      int slot;
      int lo;
      logic [31:0] elapsed;
      logic [ptt_pkg::ENTRIES-1:0] fire_mask;
      slot = -1;
      lo = -1;
      fire_mask = '0;
      case (r.op)
         ptt_pkg::OP_SET: begin
            for (int i = 0; i < ptt_pkg::ENTRIES; i++)
               if (slot < 0 && tbl_valid[i] && tbl_id[i] == r.event_id) slot = i;
            if (slot < 0) begin
               for (int i = 0; i < ptt_pkg::ENTRIES; i++)
                  if (slot < 0 && !tbl_valid[i]) slot = i;
               if (slot >= 0) begin
                  tbl_valid[slot] = 1'b1;
                  tbl_id[slot] = r.event_id;
               end
            end
            if (slot < 0) begin
               step_results.push_back('{ptt_pkg::KIND_FULL, 32'h0, 1'b1});
            end else begin
               tbl_period[slot] = r.period;
               tbl_stamp[slot] = r.now;
               tbl_killed[slot] = 1'b0;
               step_results.push_back('{ptt_pkg::KIND_OK, 32'h0, 1'b1});
            end
         end
         ptt_pkg::OP_KILL: begin
            for (int i = 0; i < ptt_pkg::ENTRIES; i++)
               if (tbl_valid[i] && tbl_id[i] == r.event_id) tbl_killed[i] = 1'b1;
            step_results.push_back('{ptt_pkg::KIND_OK, 32'h0, 1'b1});
         end
         ptt_pkg::OP_CLEAR: begin
            for (int i = 0; i < ptt_pkg::ENTRIES; i++) begin
               tbl_valid[i] = 1'b0;
               tbl_killed[i] = 1'b0;
            end
            step_results.push_back('{ptt_pkg::KIND_OK, 32'h0, 1'b1});
         end
         default: begin
            // Tick: free killed timers, restamp the expired ones
            for (int i = 0; i < ptt_pkg::ENTRIES; i++) begin
               if (tbl_valid[i]) begin
                  elapsed = r.now - tbl_stamp[i];
                  if (tbl_killed[i]) begin
                     tbl_valid[i] = 1'b0;
                     tbl_killed[i] = 1'b0;
                  end else if (elapsed > tbl_period[i]) begin
                     tbl_stamp[i] = r.now;
                     fire_mask[i] = 1'b1;
                  end
               end
            end
            // Report fired timers lowest id first
            while (fire_mask != '0) begin
               lo = -1;
               for (int i = 0; i < ptt_pkg::ENTRIES; i++)
                  if (fire_mask[i] && (lo < 0 || tbl_id[i] < tbl_id[lo])) lo = i;
               fire_mask[lo] = 1'b0;
               step_results.push_back('{ptt_pkg::KIND_FIRED, tbl_id[lo], 1'b0});
            end
            step_results.push_back('{ptt_pkg::KIND_OK, 32'h0, 1'b1});
         end
      endcase
   endfunction

   // Drive one request, wait for its transfer, then record what it should cause
   task automatic send_request(timer_req_type r);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= r.op;
      req_bus.event_id <= r.event_id;
      req_bus.period   <= r.period;
      req_bus.now      <= r.now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      op_count[r.op]++;
      step_results.delete();
      advance_timer_table(r);
      if (r.typed) begin
         pending_results.push_back('{r.typed_kind, 32'h0, 1'b1});
      end else begin
         foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
   endtask

   // Response side: check each transfer, then pick the next ready level
   initial begin
      timer_rsp_type got;
      timer_rsp_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.kind, rsp_bus.fired_id, rsp_bus.last};
            rsp_seen++;
            if (got.kind == ptt_pkg::KIND_FIRED) fired_seen++;
            if (got.kind == ptt_pkg::KIND_FULL) full_seen++;
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result kind=%0d fired_id=%h last=%0b",
                        $time, got.kind, got.fired_id, got.last);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
                   got.last !== want.last) begin
                  error_count++;
                  $display("%0t: mismatch expected kind=%0d fired_id=%h last=%0b, %s",
                           $time, want.kind, want.fired_id, want.last, "got");
                  $display("%0t:          actual   kind=%0d fired_id=%h last=%0b",
                           $time, got.kind, got.fired_id, got.last);
               end
            end
         end
         rsp_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL periodic_timer_table");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [31:0] id_pool [ID_POOL];
      logic [31:0] cur_now;
      timer_req_type r;
      int pick;

      reset <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.opcode   <= ptt_pkg::OP_SET;
      req_bus.event_id <= 32'h0;
      req_bus.period   <= 32'h0;
      req_bus.now      <= 32'h0;
      for (int i = 0; i < ptt_pkg::ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_killed[i] = 1'b0;
         tbl_id[i] = 32'h0;
         tbl_period[i] = 32'h0;
         tbl_stamp[i] = 32'h0;
      end

      // Directed rows: empty tick, kills, revive, fill to full, big tick, clear
      directed_rows = '{
         '{ptt_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_KILL, 32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_KILL, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_KILL, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h0000_0000, 32'h0000_0007, 32'h0000_0002, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h8000_0000, 32'h0000_0010, 32'h0000_0003, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h0000_FFFF, 32'h0000_0100, 32'hFFFF_FF00, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFD, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h1234_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h0F0F_0F0F, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'hF0F0_F0F0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h0000_0100, 32'h0000_0003, 32'h0000_0004, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'hFFFF_FFFE, 32'h0000_0000, 32'h8000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h3333_3333, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'hCCCC_CCCC, 32'h0000_0040, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_SET, 32'h9ABC_DEF0, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_FULL},
         '{ptt_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ptt_pkg::KIND_OK},
         '{ptt_pkg::OP_CLEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ptt_pkg::KIND_OK}
      };

      // Synchronous reset
      @(posedge clock);
      @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) send_request(directed_rows[k]);

      // Random traffic over a small id pool so sets, kills and full answers hit
      foreach (id_pool[k]) id_pool[k] = $urandom;
      cur_now = $urandom;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PHASE_ITEMS) begin
            send_idle_pct = 57;
            recv_stall_pct = 8;
         end else if (n == 2 * PHASE_ITEMS) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         if ($urandom_range(0, 19) == 0)
            cur_now = $urandom;
         else
            cur_now = cur_now + $urandom_range(0, 400);
         r = '0;
         r.now = cur_now;
         r.event_id = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : id_pool[$urandom_range(0, ID_POOL - 1)];
         pick = $urandom_range(0, 9);
         if (pick < 5)
            r.period = $urandom_range(0, 600);
         else if (pick < 8)
            r.period = $urandom;
         else if (pick == 8)
            r.period = 32'hFFFF_FFFF;
         else
            r.period = 32'h0;
         pick = $urandom_range(0, 99);
         if (pick < 45)
            r.op = ptt_pkg::OP_SET;
         else if (pick < 62)
            r.op = ptt_pkg::OP_KILL;
         else if (pick < 97)
            r.op = ptt_pkg::OP_TICK;
         else
            r.op = ptt_pkg::OP_CLEAR;
         send_request(r);
      end
      req_bus.valid <= 1'b0;

      // Drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d sets, %0d kills, %0d ticks, %0d clears under three idle mixes;",
               op_count[ptt_pkg::OP_SET], op_count[ptt_pkg::OP_KILL],
               op_count[ptt_pkg::OP_TICK], op_count[ptt_pkg::OP_CLEAR]);
      $display("checked %0d results: %0d fired reports, %0d full answers, %0d errors.",
               rsp_seen, fired_seen, full_seen, error_count);
      if (error_count == 0) begin
         $display("PASS periodic_timer_table");
      end else begin
         $display("FAIL periodic_timer_table");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_if.sv
hdl/ptt_cell.sv
hdl/periodic_timer_table.sv
tb/sv/periodic_timer_table_test.sv
